FILE: design/hcbd_pkg.sv
// Shared types and constants for the chunked body decoder.
// Used by hcbd_step and http_chunked_body_decoder; no dependencies.
package hcbd_pkg;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [23:0] HDR_TAIL = 24'h0D0A0D;

	typedef enum logic [3:0] {
		PH_HDR      = 4'd0,
		PH_SIZE     = 4'd1,
		PH_EXT      = 4'd2,
		PH_SIZE_LF  = 4'd3,
		PH_DATA     = 4'd4,
		PH_DATA_CR  = 4'd5,
		PH_DATA_LF  = 4'd6,
		PH_TRL_BEG  = 4'd7,
		PH_TRL_LINE = 4'd8,
		PH_TRL_LF   = 4'd9,
		PH_END_LF   = 4'd10,
		PH_DONE     = 4'd11,
		PH_ERR      = 4'd12
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	// Decoder state apart from the size counter, whose width is a parameter.
	typedef struct packed {
		phase_t      phase;
		logic [23:0] recent;
		logic        digit_seen;
	} dec_state_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		kind_t      kind;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.val = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.val = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.val = 4'(c - 8'h57);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

FILE: design/hcbd_step.sv
// Next-state and result logic for one byte of the chunked body decoder.
// Purely combinational; depends on hcbd_pkg.
module hcbd_step import hcbd_pkg::*; #(
	parameter int SIZE_BITS = 32
) (
	input  dec_state_t           st,
	input  logic [SIZE_BITS-1:0] cnt,
	input  logic                 skip,
	input  logic [7:0]           byte_in,
	output dec_state_t           nst,
	output logic [SIZE_BITS-1:0] ncnt,
	output result_t              res
);

	phase_t               eph;
	logic [SIZE_BITS-1:0] ecnt;
	logic                 edig;
	hex_t                 hx;

	always_comb begin
		hx   = hex_value(byte_in);
		eph  = st.phase;
		ecnt = cnt;
		edig = st.digit_seen;
		// Header search with skipping off: treat byte as start of a size line
		if (st.phase == PH_HDR && !skip) begin
			eph  = PH_SIZE;
			ecnt = '0;
			edig = 1'b0;
		end

		nst            = st;
		nst.phase      = eph;
		nst.digit_seen = edig;
		ncnt           = ecnt;
		res            = '{valid: 1'b0, data: 8'h00, kind: KIND_DATA};

		unique case (eph)
			PH_HDR: begin
				nst.recent = {st.recent[15:0], byte_in};
				if (st.recent == HDR_TAIL && byte_in == CH_LF) begin
					nst.phase      = PH_SIZE;
					nst.digit_seen = 1'b0;
					ncnt           = '0;
				end
			end
			PH_SIZE: begin
				if (hx.ok) begin
					if (ecnt[SIZE_BITS-1 -: 4] != 4'd0) begin
						nst.phase = PH_ERR;
						res       = '{valid: 1'b1, data: 8'h00, kind: KIND_ERR};
					end else begin
						ncnt           = {ecnt[SIZE_BITS-5:0], hx.val};
						nst.digit_seen = 1'b1;
					end
				end else if (!edig) begin
					nst.phase = PH_ERR;
					res       = '{valid: 1'b1, data: 8'h00, kind: KIND_ERR};
				end else if (byte_in == CH_CR) begin
					nst.phase = PH_SIZE_LF;
				end else if (byte_in == CH_SEMI || byte_in == CH_SP || byte_in == CH_TAB) begin
					nst.phase = PH_EXT;
				end else begin
					nst.phase = PH_ERR;
					res       = '{valid: 1'b1, data: 8'h00, kind: KIND_ERR};
				end
			end
			PH_EXT: begin
				if (byte_in == CH_CR) nst.phase = PH_SIZE_LF;
			end
			PH_SIZE_LF: begin
				if (byte_in != CH_LF) begin
					nst.phase = PH_ERR;
					res       = '{valid: 1'b1, data: 8'h00, kind: KIND_ERR};
				end else begin
					nst.phase = (ecnt == '0) ? PH_TRL_BEG : PH_DATA;
				end
			end
			PH_DATA: begin
				ncnt = ecnt - SIZE_BITS'(1);
				if (ecnt == SIZE_BITS'(1)) nst.phase = PH_DATA_CR;
				res = '{valid: 1'b1, data: byte_in, kind: KIND_DATA};
			end
			PH_DATA_CR: begin
				if (byte_in != CH_CR) begin
					nst.phase = PH_ERR;
					res       = '{valid: 1'b1, data: 8'h00, kind: KIND_ERR};
				end else begin
					nst.phase = PH_DATA_LF;
				end
			end
			PH_DATA_LF: begin
				if (byte_in != CH_LF) begin
					nst.phase = PH_ERR;
					res       = '{valid: 1'b1, data: 8'h00, kind: KIND_ERR};
				end else begin
					nst.phase      = PH_SIZE;
					nst.digit_seen = 1'b0;
					ncnt           = '0;
				end
			end
			PH_TRL_BEG: begin
				nst.phase = (byte_in == CH_CR) ? PH_END_LF : PH_TRL_LINE;
			end
			PH_TRL_LINE: begin
				if (byte_in == CH_CR) nst.phase = PH_TRL_LF;
			end
			PH_TRL_LF: begin
				if (byte_in != CH_LF) begin
					nst.phase = PH_ERR;
					res       = '{valid: 1'b1, data: 8'h00, kind: KIND_ERR};
				end else begin
					nst.phase = PH_TRL_BEG;
				end
			end
			PH_END_LF: begin
				if (byte_in != CH_LF) begin
					nst.phase = PH_ERR;
					res       = '{valid: 1'b1, data: 8'h00, kind: KIND_ERR};
				end else begin
					nst.phase = PH_DONE;
					res       = '{valid: 1'b1, data: 8'h00, kind: KIND_END};
				end
			end
			default: begin
				// done, error and unused codes: drop the byte
			end
		endcase
	end

endmodule

FILE: design/http_chunked_body_decoder.sv
// HTTP chunked transfer body decoder, top level.
// Depends on hcbd_pkg and hcbd_step.
//
// Usage:
//   Input channel (in_valid/in_stall/in_byte) carries the raw response one
//   item (byte) at a time. Output channel (out_valid/out_stall/out_byte/kind)
//   carries payload bytes (kind 0), one end-of-body item (kind 1) or one
//   error item (kind 2). Many input items produce no output item.
//   cfg_we/cfg_wdata write skip_header; write it only while the block idles.
//   Path: an accepted item waits in the input register, is decoded
//   combinationally and its result is loaded into the result register,
//   from which the output channel takes it. Throughput: one item per clock
//   while out_stall does not hold a full result register, set by the single
//   decode step between the input register and the result register.
//   Reset: skip_header = 1, decoder in header search, no item held.
//   Stall: while out_stall holds a full result register, a held input item
//   stays in the input register and in_stall rises; nothing is lost or repeated.
//   After end of body or an error every further byte is dropped until reset.
module http_chunked_body_decoder import hcbd_pkg::*; #(
	parameter int SIZE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] kind,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);

	logic                 skip_q;
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	dec_state_t           st_q;
	logic [SIZE_BITS-1:0] cnt_q;
	result_t              res_q;

	dec_state_t           st_nxt;
	logic [SIZE_BITS-1:0] cnt_nxt;
	result_t              res_nxt;
	logic                 adv;

	// Advance the decode step whenever the result register is free or draining
	assign adv      = !res_q.valid || !out_stall;
	assign in_stall = valid_s1 && !adv;

	hcbd_step #(.SIZE_BITS(SIZE_BITS)) u_step (
		.st      (st_q),
		.cnt     (cnt_q),
		.skip    (skip_q),
		.byte_in (byte_s1),
		.nst     (st_nxt),
		.ncnt    (cnt_nxt),
		.res     (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b1;
		end else if (cfg_we) begin
			skip_q <= cfg_wdata;
		end
	end

	// Input register: take a new item when the held one moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// Decoder state: update only when the held item is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '{phase: PH_HDR, recent: 24'h000000, digit_seen: 1'b0};
			cnt_q <= '0;
		end else if (valid_s1 && adv) begin
			st_q  <= st_nxt;
			cnt_q <= cnt_nxt;
		end
	end

	// Result register: load a new result, or clear it once the old one drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (adv) begin
			res_q.valid <= valid_s1 && res_nxt.valid;
			if (valid_s1 && res_nxt.valid) begin
				res_q.data <= res_nxt.data;
				res_q.kind <= res_nxt.kind;
			end
		end
	end

	assign out_valid = res_q.valid;
	assign out_byte  = res_q.data;
	assign kind      = res_q.kind;

	// A result carries only one of the three defined kinds
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == KIND_DATA || kind == KIND_END || kind == KIND_ERR))
		else $error("illegal result kind");

	// End and error items carry a zero byte
	a_ctrl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != KIND_DATA) |-> (out_byte == 8'h00))
		else $error("nonzero byte on control item");

	// Payload phase never runs with nothing left to send
	a_data_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_DATA) |-> (cnt_q != '0))
		else $error("payload phase with zero count");

	// Once ended or failed, the decoder stays there
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_DONE || st_q.phase == PH_ERR) |=> $stable(st_q.phase))
		else $error("left terminal phase");

endmodule
